### hw/rtl/sst_pkg.sv
// Shared types, constants and helpers for the scoped symbol table.
package sst_pkg;

  localparam int unsigned LocalDepthDef  = 128;
  localparam int unsigned GlobalDepthDef = 1024;
  localparam int unsigned ConstDepthDef  = 1024;
  localparam int unsigned NameChars      = 16;
  localparam int unsigned LocalFrameLimit = 255;
  localparam int unsigned LocalBytesW    = 17;

  typedef enum logic [2:0] {
    FN_ADDR_LOOKUP  = 3'd0,
    FN_CONST_LOOKUP = 3'd1,
    FN_TYPE_LOOKUP  = 3'd2,
    FN_ADD_LOCAL    = 3'd3,
    FN_ADD_GLOBAL   = 3'd4,
    FN_ADD_FUNC     = 3'd5,
    FN_ADD_CONST    = 3'd6,
    FN_RESET_LOCALS = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDECL    = 2'd2,
    ST_RESERVED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_FUNC_TYPE  = 2'd0,
    REG_CONST_TYPE = 2'd1,
    REG_LOCAL_FLAG = 2'd2,
    REG_NONE       = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    TBL_LOC = 2'd0,
    TBL_GLB = 2'd1,
    TBL_CON = 2'd2,
    TBL_NONE = 2'd3
  } tbl_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic [7:0]  len;
    logic [63:0] lo;
    logic [63:0] hi;
  } name_t;

  typedef struct packed {
    name_t       name;
    logic [7:0]  kind;
    logic [15:0] data;
  } entry_t;

  // Keep only the characters that take part in matching.
  function automatic name_t mask_name(logic [7:0] len, logic [63:0] lo, logic [63:0] hi);
    name_t       n;
    logic [8:0]  used;
    n.len = len;
    n.lo  = lo;
    n.hi  = hi;
    used  = (len > 8'(NameChars)) ? 9'(NameChars) : {1'b0, len};
    for (int b = 0; b < 8; b++) begin
      if (9'(b) >= used) n.lo[8*b +: 8] = 8'h00;
      if (9'(b + 8) >= used) n.hi[8*b +: 8] = 8'h00;
    end
    return n;
  endfunction

endpackage

### hw/rtl/sst_table.sv
// One entry store of the symbol table: single write port, registered read.
module sst_table #(
  parameter int unsigned DEPTH = sst_pkg::GlobalDepthDef,
  parameter int unsigned IDX_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  sst_pkg::entry_t   wentry_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output sst_pkg::entry_t   rentry_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sst_pkg::entry_t mem [DEPTH];
  sst_pkg::entry_t rentry_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i[AW-1:0]] <= wentry_i;
    end
    rentry_q <= mem[raddr_i[AW-1:0]];
  end

  assign rentry_o = rentry_q;
endmodule

### hw/rtl/scoped_symbol_table_core.sv
// Top level of the scoped symbol table: scan sequencer over three entry stores.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | func, name_len, name_lo/hi, sym_type, size, value
//  out     | output    | out_valid_o/out_stall_i | status, result
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Adds and local reset pass from the accept state straight to the result state.
// A lookup scans each store it visits entry by entry; a hit ends the scan at that
// entry. Worst case is a type lookup that misses: it reads every entry of the const,
// local and global stores before the result.
// Reset empties all counts; stores need no clearing. One item is in flight at a
// time; input stalls until the result beat is taken.
module scoped_symbol_table_core #(
  parameter int unsigned LOCAL_DEPTH  = sst_pkg::LocalDepthDef,
  parameter int unsigned GLOBAL_DEPTH = sst_pkg::GlobalDepthDef,
  parameter int unsigned CONST_DEPTH  = sst_pkg::ConstDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  name_len_i,
  input  logic [63:0] name_lo_i,
  input  logic [63:0] name_hi_i,
  input  logic [7:0]  sym_type_i,
  input  logic [15:0] size_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  localparam int unsigned LCW = $clog2(LOCAL_DEPTH + 1);
  localparam int unsigned GCW = $clog2(GLOBAL_DEPTH + 1);
  localparam int unsigned CCW = $clog2(CONST_DEPTH + 1);
  localparam int unsigned MW1 = (LCW > GCW) ? LCW : GCW;
  localparam int unsigned IDX_W = (MW1 > CCW) ? MW1 : CCW;
  localparam int unsigned LBW = sst_pkg::LocalBytesW;

  sst_pkg::state_e state_q, state_d;
  sst_pkg::tbl_e   sel_q, sel_d;
  sst_pkg::func_e  op_q, op_d;
  sst_pkg::name_t  key_q, key_d, key_in;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  sst_pkg::status_e status_q, status_d;
  logic [15:0]      result_q, result_d;
  logic [LCW-1:0]   lcount_q, lcount_d;
  logic [GCW-1:0]   gcount_q, gcount_d;
  logic [CCW-1:0]   ccount_q, ccount_d;
  logic [LBW-1:0]   lbytes_q, lbytes_d;
  logic [15:0]      gbytes_q, gbytes_d;
  logic [7:0]       func_type_q, const_type_q, local_flag_q;

  logic in_acc, out_acc, hit, last, more;
  logic loc_we, glb_we, con_we;
  sst_pkg::entry_t wentry, loc_rd, glb_rd, con_rd, cur_rd;
  logic [IDX_W-1:0] n_cur;

  assign in_stall_o  = (state_q != sst_pkg::S_IDLE);
  assign in_acc      = in_valid_i && (state_q == sst_pkg::S_IDLE);
  assign out_valid_o = (state_q == sst_pkg::S_DONE);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign status_o    = status_q;
  assign result_o    = result_q;
  assign cfg_ready_o = 1'b1;
  assign key_in      = sst_pkg::mask_name(name_len_i, name_lo_i, name_hi_i);

  // Entry written on an add, shared by all stores.
  always_comb begin
    wentry.name = key_in;
    wentry.kind = sym_type_i;
    wentry.data = value_i;
    unique case (sst_pkg::func_e'(func_i))
      sst_pkg::FN_ADD_LOCAL:  wentry.data = lbytes_q[15:0];
      sst_pkg::FN_ADD_GLOBAL: wentry.data = gbytes_q;
      sst_pkg::FN_ADD_FUNC:   wentry.kind = func_type_q;
      default: ;
    endcase
  end

  assign loc_we = in_acc && (func_i == sst_pkg::FN_ADD_LOCAL) &&
                  (lcount_q != LCW'(LOCAL_DEPTH)) &&
                  !(lbytes_q > LBW'(sst_pkg::LocalFrameLimit));
  assign glb_we = in_acc && ((func_i == sst_pkg::FN_ADD_GLOBAL) ||
                  (func_i == sst_pkg::FN_ADD_FUNC)) && (gcount_q != GCW'(GLOBAL_DEPTH));
  assign con_we = in_acc && (func_i == sst_pkg::FN_ADD_CONST) &&
                  (ccount_q != CCW'(CONST_DEPTH));

  sst_table #(.DEPTH(LOCAL_DEPTH), .IDX_W(IDX_W)) u_loc (
    .clk_i, .we_i(loc_we), .waddr_i(IDX_W'(lcount_q)), .wentry_i(wentry),
    .raddr_i(idx_q), .rentry_o(loc_rd));
  sst_table #(.DEPTH(GLOBAL_DEPTH), .IDX_W(IDX_W)) u_glb (
    .clk_i, .we_i(glb_we), .waddr_i(IDX_W'(gcount_q)), .wentry_i(wentry),
    .raddr_i(idx_q), .rentry_o(glb_rd));
  sst_table #(.DEPTH(CONST_DEPTH), .IDX_W(IDX_W)) u_con (
    .clk_i, .we_i(con_we), .waddr_i(IDX_W'(ccount_q)), .wentry_i(wentry),
    .raddr_i(idx_q), .rentry_o(con_rd));

  always_comb begin
    unique case (sel_q)
      sst_pkg::TBL_LOC: begin cur_rd = loc_rd; n_cur = IDX_W'(lcount_q); end
      sst_pkg::TBL_GLB: begin cur_rd = glb_rd; n_cur = IDX_W'(gcount_q); end
      sst_pkg::TBL_CON: begin cur_rd = con_rd; n_cur = IDX_W'(ccount_q); end
      default:          begin cur_rd = con_rd; n_cur = '0; end
    endcase
  end

  assign hit  = pend_q && (cur_rd.name == key_q);
  assign more = (idx_q < n_cur);
  assign last = !pend_q && !more;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sst_pkg::S_IDLE: begin
        if (in_acc) begin
          if (func_i == sst_pkg::FN_ADDR_LOOKUP || func_i == sst_pkg::FN_CONST_LOOKUP ||
              func_i == sst_pkg::FN_TYPE_LOOKUP) state_d = sst_pkg::S_SCAN;
          else state_d = sst_pkg::S_DONE;
        end
      end
      sst_pkg::S_SCAN: begin
        if (hit) state_d = sst_pkg::S_DONE;
        else if (last && (sel_q == sst_pkg::TBL_GLB ||
                 (sel_q == sst_pkg::TBL_CON && op_q == sst_pkg::FN_CONST_LOOKUP)))
          state_d = sst_pkg::S_DONE;
      end
      sst_pkg::S_DONE: begin
        if (out_acc) state_d = sst_pkg::S_IDLE;
      end
      default: state_d = sst_pkg::S_IDLE;
    endcase
  end

  // Datapath and counters.
  always_comb begin
    sel_d    = sel_q;
    op_d     = op_q;
    key_d    = key_q;
    idx_d    = idx_q;
    pend_d   = 1'b0;
    status_d = status_q;
    result_d = result_q;
    lcount_d = lcount_q;
    gcount_d = gcount_q;
    ccount_d = ccount_q;
    lbytes_d = lbytes_q;
    gbytes_d = gbytes_q;
    unique case (state_q)
      sst_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d     = sst_pkg::func_e'(func_i);
          key_d    = key_in;
          idx_d    = '0;
          status_d = sst_pkg::ST_OK;
          result_d = '0;
          unique case (sst_pkg::func_e'(func_i))
            sst_pkg::FN_ADDR_LOOKUP:  sel_d = sst_pkg::TBL_LOC;
            sst_pkg::FN_CONST_LOOKUP: sel_d = sst_pkg::TBL_CON;
            sst_pkg::FN_TYPE_LOOKUP:  sel_d = sst_pkg::TBL_CON;
            sst_pkg::FN_ADD_LOCAL: begin
              if (loc_we) begin
                lcount_d = lcount_q + LCW'(1);
                lbytes_d = lbytes_q + LBW'(size_i);
              end else status_d = sst_pkg::ST_OVERFLOW;
            end
            sst_pkg::FN_ADD_GLOBAL, sst_pkg::FN_ADD_FUNC: begin
              if (glb_we) begin
                gcount_d = gcount_q + GCW'(1);
                if (func_i == sst_pkg::FN_ADD_GLOBAL) gbytes_d = gbytes_q + size_i;
              end else status_d = sst_pkg::ST_OVERFLOW;
            end
            sst_pkg::FN_ADD_CONST: begin
              if (con_we) ccount_d = ccount_q + CCW'(1);
              else status_d = sst_pkg::ST_OVERFLOW;
            end
            sst_pkg::FN_RESET_LOCALS: begin
              lcount_d = '0;
              lbytes_d = '0;
            end
          endcase
        end
      end
      sst_pkg::S_SCAN: begin
        if (hit) begin
          unique case (sel_q)
            sst_pkg::TBL_LOC: result_d = (op_q == sst_pkg::FN_TYPE_LOOKUP) ?
                                {8'h00, cur_rd.kind | local_flag_q} : cur_rd.data;
            sst_pkg::TBL_GLB: result_d = (op_q == sst_pkg::FN_TYPE_LOOKUP) ?
                                {8'h00, cur_rd.kind} : cur_rd.data;
            default:          result_d = (op_q == sst_pkg::FN_TYPE_LOOKUP) ?
                                {8'h00, const_type_q} : cur_rd.data;
          endcase
        end else if (last) begin
          // Advance to the next store in search order, or report a miss.
          idx_d = '0;
          priority if (sel_q == sst_pkg::TBL_CON && op_q == sst_pkg::FN_TYPE_LOOKUP) begin
            sel_d = sst_pkg::TBL_LOC;
          end else if (sel_q == sst_pkg::TBL_LOC) begin
            sel_d = sst_pkg::TBL_GLB;
          end else begin
            status_d = sst_pkg::ST_UNDECL;
            result_d = (op_q == sst_pkg::FN_ADDR_LOOKUP) ? 16'hFFFF : 16'h0000;
          end
        end else if (more) begin
          pend_d = 1'b1;
          idx_d  = idx_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sst_pkg::S_IDLE;
      sel_q        <= sst_pkg::TBL_LOC;
      op_q         <= sst_pkg::FN_ADDR_LOOKUP;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      status_q     <= sst_pkg::ST_OK;
      result_q     <= '0;
      lcount_q     <= '0;
      gcount_q     <= '0;
      ccount_q     <= '0;
      lbytes_q     <= '0;
      gbytes_q     <= '0;
      func_type_q  <= 8'd8;
      const_type_q <= 8'd1;
      local_flag_q <= 8'd128;
    end else begin
      state_q  <= state_d;
      sel_q    <= sel_d;
      op_q     <= op_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      status_q <= status_d;
      result_q <= result_d;
      lcount_q <= lcount_d;
      gcount_q <= gcount_d;
      ccount_q <= ccount_d;
      lbytes_q <= lbytes_d;
      gbytes_q <= gbytes_d;
      if (cfg_valid_i) begin
        unique case (sst_pkg::reg_e'(cfg_index_i))
          sst_pkg::REG_FUNC_TYPE:  func_type_q  <= cfg_data_i;
          sst_pkg::REG_CONST_TYPE: const_type_q <= cfg_data_i;
          sst_pkg::REG_LOCAL_FLAG: local_flag_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

`ifndef SYNTHESIS
  a_lcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcount_q <= LCW'(LOCAL_DEPTH)) else $error("local count beyond depth");
  a_gcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcount_q <= GCW'(GLOBAL_DEPTH)) else $error("global count beyond depth");
  a_pend_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == sst_pkg::S_SCAN && idx_q != '0)) else $error("stray read pending");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != sst_pkg::ST_RESERVED)) else $error("bad status");
  a_const_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sst_pkg::S_SCAN && op_q == sst_pkg::FN_CONST_LOOKUP) |->
    (sel_q == sst_pkg::TBL_CON)) else $error("const lookup left const store");
`endif
endmodule
